/* sv/ptps_pkg.sv */
package ptps_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int RANGE_BITS_DEF   = 21;
  localparam int TAB_LEN          = 24;
  localparam int GUARD            = 4;
  // Width of the signed CORDIC datapath: range plus guard bits plus headroom.
  localparam int CW               = 48;
  localparam logic [23:0] INV_GAIN_Q24   = 24'd10187996;
  localparam logic [23:0] KM_PER_KNOT_MS = 24'd9050195;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 21;

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_DESTROY = 2'd1,
    OP_RESTART = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    CFG_SPEED     = 3'd0,
    CFG_HEADING   = 3'd1,
    CFG_FRIENDLY  = 3'd2,
    CFG_TERRITORY = 3'd3,
    CFG_START_RNG = 3'd4,
    CFG_START_AZ  = 3'd5
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIST,
    ST_SCALE_IN,
    ST_ROTATE,
    ST_SUM,
    ST_VECTOR,
    ST_SCALE_OUT,
    ST_FINISH,
    ST_OUTPUT
  } state_t;

  // Control from the sequencer to the CORDIC unit.
  typedef struct packed {
    logic load;
    logic vector_mode;
    logic step;
  } cordic_ctl_t;

  // Arctangent table in 32-bit binary angle units.
  function automatic logic [31:0] atan_lut(input logic [4:0] i);
    logic [31:0] v;
    begin
      case (i)
        5'd0:  v = 32'd536870912;
        5'd1:  v = 32'd316933406;
        5'd2:  v = 32'd167458907;
        5'd3:  v = 32'd85004756;
        5'd4:  v = 32'd42667331;
        5'd5:  v = 32'd21354465;
        5'd6:  v = 32'd10679838;
        5'd7:  v = 32'd5340245;
        5'd8:  v = 32'd2670163;
        5'd9:  v = 32'd1335087;
        5'd10: v = 32'd667544;
        5'd11: v = 32'd333772;
        5'd12: v = 32'd166886;
        5'd13: v = 32'd83443;
        5'd14: v = 32'd41722;
        5'd15: v = 32'd20861;
        5'd16: v = 32'd10430;
        5'd17: v = 32'd5215;
        5'd18: v = 32'd2608;
        5'd19: v = 32'd1304;
        5'd20: v = 32'd652;
        5'd21: v = 32'd326;
        5'd22: v = 32'd163;
        5'd23: v = 32'd81;
        default: v = 32'd0;
      endcase
      return v;
    end
  endfunction

endpackage

/* sv/ptps_if.sv */
interface ptps_in_if;
  import ptps_pkg::*;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [15:0] dt_ms;
  modport source (output valid, output op, output dt_ms, input ready);
  modport sink   (input valid, input op, input dt_ms, output ready);
endinterface

interface ptps_out_if;
  import ptps_pkg::*;
  logic        valid;
  logic        ready;
  logic [20:0] range_now;
  logic [15:0] azimuth_now;
  logic        alive_flag;
  logic        in_territory;
  logic [31:0] sweep_age_ms;
  modport source (output valid, output range_now, output azimuth_now, output alive_flag,
                  output in_territory, output sweep_age_ms, input ready);
  modport sink   (input valid, input range_now, input azimuth_now, input alive_flag,
                  input in_territory, input sweep_age_ms, output ready);
endinterface

/* sv/ptps_serial_mul.sv */
// Shift-and-add multiplier: one bit of the multiplier operand per cycle.
module ptps_serial_mul #(
  parameter int AW = 48,
  parameter int BW = 24
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [AW-1:0]    a_in,
  input  logic [BW-1:0]    b_in,
  output logic             done,
  output logic [AW+BW-1:0] prod
);
  localparam int CNT_W = $clog2(BW + 1);

  logic [AW+BW-1:0] acc_r, acc_nxt;
  logic [AW+BW-1:0] mcand_r, mcand_nxt;
  logic [BW-1:0]    mplier_r, mplier_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;

  // Next values: add the shifted multiplicand when the low multiplier bit is set.
  always_comb begin
    acc_nxt    = acc_r;
    mcand_nxt  = mcand_r;
    mplier_nxt = mplier_r;
    cnt_nxt    = cnt_r;
    busy_nxt   = busy_r;
    done_nxt   = 1'b0;
    if (start) begin
      acc_nxt    = '0;
      mcand_nxt  = {{BW{1'b0}}, a_in};
      mplier_nxt = b_in;
      cnt_nxt    = CNT_W'(BW);
      busy_nxt   = 1'b1;
    end else if (busy_r) begin
      if (mplier_r[0]) begin
        acc_nxt = acc_r + mcand_r;
      end
      mcand_nxt  = mcand_r << 1;
      mplier_nxt = mplier_r >> 1;
      cnt_nxt    = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    acc_r    <= acc_nxt;
    mcand_r  <= mcand_nxt;
    mplier_r <= mplier_nxt;
  end

  assign done = done_r;
  assign prod = acc_r;
endmodule

/* sv/ptps_cordic.sv */
// Shared CORDIC unit: one micro-rotation per step, in rotation or vectoring mode.
module ptps_cordic (
  input  logic                   clk,
  input  ptps_pkg::cordic_ctl_t  ctl,
  input  logic signed [47:0]     x_in,
  input  logic signed [47:0]     y_in,
  input  logic [31:0]            z_in,
  output logic signed [47:0]     x_out,
  output logic signed [47:0]     y_out,
  output logic [31:0]            z_out
);
  import ptps_pkg::*;

  logic signed [CW-1:0] x_r, x_nxt, y_r, y_nxt;
  logic [31:0]          z_r, z_nxt;
  logic [4:0]           i_r, i_nxt;
  logic signed [CW-1:0] dx, dy;
  logic                 dir_pos;

  // Arithmetic shifts give floor shifts; direction from angle sign or y sign.
  always_comb begin
    dx      = y_r >>> i_r;
    dy      = x_r >>> i_r;
    dir_pos = ctl.vector_mode ? !y_r[CW-1] : !z_r[31];
    x_nxt   = x_r;
    y_nxt   = y_r;
    z_nxt   = z_r;
    i_nxt   = i_r;
    if (ctl.load) begin
      x_nxt = x_in;
      y_nxt = y_in;
      z_nxt = z_in;
      i_nxt = '0;
    end else if (ctl.step) begin
      i_nxt = i_r + 5'd1;
      if (ctl.vector_mode) begin
        if (dir_pos) begin
          x_nxt = x_r + dx; y_nxt = y_r - dy; z_nxt = z_r + atan_lut(i_r);
        end else begin
          x_nxt = x_r - dx; y_nxt = y_r + dy; z_nxt = z_r - atan_lut(i_r);
        end
      end else begin
        if (dir_pos) begin
          x_nxt = x_r - dx; y_nxt = y_r + dy; z_nxt = z_r - atan_lut(i_r);
        end else begin
          x_nxt = x_r + dx; y_nxt = y_r - dy; z_nxt = z_r + atan_lut(i_r);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    y_r <= y_nxt;
    z_r <= z_nxt;
    i_r <= i_nxt;
  end

  assign x_out = x_r;
  assign y_out = y_r;
  assign z_out = z_r;
endmodule

/* sv/polar_track_position_step.sv */
// Polar dead-reckoning track for one radar target. Each accepted word gives exactly one
// result word showing the track after the operation. Destroy, restart and idle codes
// pass through the finish and output states before the result register is loaded; a
// tick of a destroyed target passes through the distance and output states. A tick of
// a live target runs a bit-serial multiply for the distance; a zero distance then goes
// on to the finish and output states. A non-zero distance adds a serial gain scaling of
// the rotation input, CORDIC_STEPS rotation steps (16 by default, capped at the table
// length), a load state for the vectoring pass, as many vectoring steps and a serial
// gain scaling of the magnitude. The serial shift-and-add multiplier and the single
// shared CORDIC stage set the length of a tick. One word is processed at a time; the
// input is ready again in the cycle after the result has been taken.
module polar_track_position_step #(
  parameter int CORDIC_STEPS = ptps_pkg::CORDIC_STEPS_DEF,
  parameter int RANGE_BITS   = ptps_pkg::RANGE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [ptps_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ptps_pkg::CFG_DATA_W-1:0] cfg_data,
  ptps_in_if.sink                        in_ch,
  ptps_out_if.source                     out_ch
);
  import ptps_pkg::*;

  localparam int STEPS = (CORDIC_STEPS < TAB_LEN) ? CORDIC_STEPS : TAB_LEN;
  localparam logic [RANGE_BITS-1:0] RMAX = {RANGE_BITS{1'b1}};

  // Configuration registers.
  logic [10:0] speed_r;
  logic [15:0] heading_r, start_az_r;
  logic        friendly_r;
  logic [20:0] terr_r, start_rng_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_r     <= '0;
      heading_r   <= '0;
      friendly_r  <= 1'b0;
      terr_r      <= 21'd163840;
      start_rng_r <= '0;
      start_az_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_SPEED:     speed_r     <= cfg_data[10:0];
        CFG_HEADING:   heading_r   <= cfg_data[15:0];
        CFG_FRIENDLY:  friendly_r  <= cfg_data[0];
        CFG_TERRITORY: terr_r      <= cfg_data;
        CFG_START_RNG: start_rng_r <= cfg_data;
        CFG_START_AZ:  start_az_r  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Track state and sequencer registers.
  logic [RANGE_BITS-1:0] range_r, range_nxt;
  logic [15:0]           az_r, az_nxt;
  logic                  alive_r, alive_nxt, pen_r, pen_nxt;
  logic [31:0]           timer_r, timer_nxt;
  state_t                st_r, st_nxt;
  logic [4:0]            step_r, step_nxt;
  logic [1:0]            op_r;
  logic [15:0]           dt_r;
  logic                  mul_go_r, mul_go_nxt;
  logic                  fold_r, fold_nxt;
  logic [31:0]           th_r, th_nxt;
  logic [31:0]           dist_r, dist_nxt;

  // Output register.
  logic                  ovalid_r;
  logic [20:0]           orange_r;
  logic [15:0]           oaz_r;
  logic                  oalive_r, open_r;
  logic [31:0]           otimer_r;

  // Serial multiplier operands.
  logic [47:0] mul_a;
  logic [23:0] mul_b;
  logic        mul_done;
  logic [71:0] mul_p;

  ptps_serial_mul #(.AW(48), .BW(24)) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_go_r),
    .a_in  (mul_a),
    .b_in  (mul_b),
    .done  (mul_done),
    .prod  (mul_p)
  );

  cordic_ctl_t          cctl;
  logic signed [CW-1:0] cx_in, cy_in, cx, cy;
  logic [31:0]          cz_in, cz;

  ptps_cordic u_cordic (
    .clk   (clk),
    .ctl   (cctl),
    .x_in  (cx_in),
    .y_in  (cy_in),
    .z_in  (cz_in),
    .x_out (cx),
    .y_out (cy),
    .z_out (cz)
  );

  // Multiplier operand select by phase.
  always_comb begin
    case (st_r)
      ST_DIST:      begin mul_a = 48'(27'(speed_r) * 27'(dt_r));
                          mul_b = KM_PER_KNOT_MS; end
      ST_SCALE_IN:  begin mul_a = 48'(dist_r) << GUARD; mul_b = INV_GAIN_Q24; end
      ST_SCALE_OUT: begin mul_a = cx[CW-1] ? '0 : 48'(cx); mul_b = INV_GAIN_Q24; end
      default:      begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // Radial sum and its fold for the vectoring pass.
  logic signed [CW-1:0] sum_a, va, vb;
  logic [31:0]          vz;
  always_comb begin
    sum_a = $signed(CW'(range_r) << GUARD) + cx;
    if (sum_a < 0) begin
      va = -sum_a; vb = -cy; vz = 32'h8000_0000;
    end else begin
      va = sum_a;  vb = cy;  vz = '0;
    end
  end

  // Rounded products.
  logic [71:0] p_in_rnd, p_out_rnd, p_dist_rnd;
  logic [RANGE_BITS-1:0] mag_sat;
  logic [43:0] mag;
  assign p_dist_rnd = mul_p + 72'h8000_0000;
  assign p_in_rnd   = mul_p + 72'h80_0000;
  assign p_out_rnd  = mul_p + 72'h800_0000;
  assign mag        = p_out_rnd[71:28];
  assign mag_sat    = (mag > 44'(RMAX)) ? RMAX : mag[RANGE_BITS-1:0];

  logic [31:0] w_rnd;
  assign w_rnd = cz + 32'h8000;

  logic [32:0] tsum;
  assign tsum = {1'b0, timer_r} + 33'(dt_r);

  logic [RANGE_BITS-1:0] srng;
  assign srng = (22'(start_rng_r) > 22'(RMAX)) ? RMAX : RANGE_BITS'(start_rng_r);

  // Next-state logic.
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE:      if (in_ch.valid && !ovalid_r) begin
                      st_nxt = (op_t'(in_ch.op) == OP_TICK) ? ST_DIST : ST_FINISH;
                    end
      ST_DIST:      if (!alive_r) st_nxt = ST_OUTPUT;
                    else if (mul_done) begin
                      st_nxt = (p_dist_rnd[63:32] == 32'd0) ? ST_FINISH : ST_SCALE_IN;
                    end
      ST_SCALE_IN:  if (mul_done) st_nxt = ST_ROTATE;
      ST_ROTATE:    if (step_r == 5'(STEPS - 1)) st_nxt = ST_SUM;
      ST_SUM:       st_nxt = ST_VECTOR;
      ST_VECTOR:    if (step_r == 5'(STEPS - 1)) st_nxt = ST_SCALE_OUT;
      ST_SCALE_OUT: if (mul_done) st_nxt = ST_FINISH;
      ST_FINISH:    st_nxt = ST_OUTPUT;
      ST_OUTPUT:    st_nxt = ST_IDLE;
      default:      st_nxt = ST_IDLE;
    endcase
  end

  // Datapath and control outputs per state.
  always_comb begin
    range_nxt  = range_r;
    az_nxt     = az_r;
    alive_nxt  = alive_r;
    pen_nxt    = pen_r;
    timer_nxt  = timer_r;
    step_nxt   = step_r;
    mul_go_nxt = 1'b0;
    fold_nxt   = fold_r;
    th_nxt     = th_r;
    dist_nxt   = dist_r;
    cctl       = '0;
    cx_in      = '0;
    cy_in      = '0;
    cz_in      = '0;
    case (st_r)
      ST_IDLE: if (in_ch.valid && !ovalid_r && op_t'(in_ch.op) == OP_TICK) begin
        mul_go_nxt = 1'b1;
      end
      ST_DIST: if (alive_r && mul_done) begin
        dist_nxt   = p_dist_rnd[63:32];
        th_nxt     = {heading_r - az_r, 16'h0};
        fold_nxt   = (th_nxt[31:30] == 2'd1) || (th_nxt[31:30] == 2'd2);
        mul_go_nxt = (p_dist_rnd[63:32] != 32'd0);
      end
      ST_SCALE_IN: if (mul_done) begin
        cctl.load = 1'b1;
        cx_in     = fold_r ? -$signed(CW'(p_in_rnd[71:24])) : $signed(CW'(p_in_rnd[71:24]));
        cz_in     = fold_r ? th_r + 32'h8000_0000 : th_r;
        step_nxt  = '0;
      end
      ST_ROTATE: begin
        cctl.step = 1'b1;
        step_nxt  = step_r + 5'd1;
      end
      ST_SUM: begin
        cctl.load        = 1'b1;
        cctl.vector_mode = 1'b1;
        cx_in            = va;
        cy_in            = vb;
        cz_in            = vz;
        step_nxt         = '0;
      end
      ST_VECTOR: begin
        cctl.step        = 1'b1;
        cctl.vector_mode = 1'b1;
        step_nxt         = step_r + 5'd1;
        if (step_r == 5'(STEPS - 1)) mul_go_nxt = 1'b1;
      end
      ST_SCALE_OUT: if (mul_done) begin
        range_nxt = mag_sat;
        az_nxt    = az_r + w_rnd[31:16];
      end
      ST_FINISH: begin
        case (op_t'(op_r))
          OP_TICK: if (alive_r) begin
            if (range_r <= RANGE_BITS'(terr_r) && 33'(range_r) <= 33'(terr_r) && !friendly_r)
              pen_nxt = 1'b1;
            if (33'(range_r) <= 33'(terr_r) && !friendly_r) pen_nxt = 1'b1;
            timer_nxt = tsum[32] ? 32'hFFFF_FFFF : tsum[31:0];
          end
          OP_DESTROY: alive_nxt = 1'b0;
          OP_RESTART: begin
            range_nxt = srng;
            az_nxt    = start_az_r;
            alive_nxt = 1'b1;
            pen_nxt   = 1'b0;
            timer_nxt = '0;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= ST_IDLE;
      range_r  <= '0;
      az_r     <= '0;
      alive_r  <= 1'b1;
      pen_r    <= 1'b0;
      timer_r  <= '0;
      mul_go_r <= 1'b0;
      ovalid_r <= 1'b0;
      step_r   <= '0;
    end else begin
      st_r     <= st_nxt;
      range_r  <= range_nxt;
      az_r     <= az_nxt;
      alive_r  <= alive_nxt;
      pen_r    <= pen_nxt;
      timer_r  <= timer_nxt;
      mul_go_r <= mul_go_nxt;
      step_r   <= step_nxt;
      if (st_r == ST_OUTPUT) ovalid_r <= 1'b1;
      else if (out_ch.ready) ovalid_r <= 1'b0;
    end
    fold_r <= fold_nxt;
    th_r   <= th_nxt;
    dist_r <= dist_nxt;
    if (st_r == ST_IDLE && in_ch.valid && !ovalid_r) begin
      op_r <= in_ch.op;
      dt_r <= in_ch.dt_ms;
    end
    if (st_r == ST_OUTPUT) begin
      orange_r <= (33'(range_r) > 33'h1F_FFFF) ? 21'h1F_FFFF : 21'(range_r);
      oaz_r    <= az_r;
      oalive_r <= alive_r;
      open_r   <= pen_r;
      otimer_r <= timer_r;
    end
  end

  assign in_ch.ready         = (st_r == ST_IDLE) && !ovalid_r;
  assign out_ch.valid        = ovalid_r;
  assign out_ch.range_now    = orange_r;
  assign out_ch.azimuth_now  = oaz_r;
  assign out_ch.alive_flag   = oalive_r;
  assign out_ch.in_territory = open_r;
  assign out_ch.sweep_age_ms = otimer_r;

  // A new word is never taken while a result waits.
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |-> !out_ch.valid) else $error("accept while result held");
  // Results appear only after the output state.
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(st_r == ST_OUTPUT)) else $error("spurious result");
  // The timer never decreases except through a restart.
  a_timer_mono: assert property (@(posedge clk) disable iff (!rst_n)
    (timer_r < $past(timer_r)) |-> $past(st_r == ST_FINISH && op_r == OP_RESTART))
    else $error("timer went backwards");
endmodule

/* bench/ptps_track_checker.sv */
`timescale 1ns / 1ps

module ptps_track_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [20:0] cfg_data,
  ptps_in_if.source   in_mon,
  ptps_out_if.sink    out_mon,
  output int          fail_count,
  output int          pending_words
);
  import ptps_pkg::*;

  typedef struct packed {
    logic [20:0] range_now;
    logic [15:0] azimuth_now;
    logic        alive_flag;
    logic        in_territory;
    logic [31:0] sweep_age_ms;
  } track_word_t;

  localparam logic [63:0] RANGE_CAP = 64'h1F_FFFF;

  // Shadow copy of the configuration and of the track.
  logic [10:0] speed_q;
  logic [15:0] heading_q;
  logic        friendly_q;
  logic [20:0] territory_q;
  logic [20:0] start_rng_q;
  logic [15:0] start_az_q;
  logic [63:0] trk_range;
  logic [15:0] trk_az;
  logic        trk_alive;
  logic        trk_pen;
  logic [31:0] trk_timer;

  track_word_t expected_track[$];

  assign pending_words = expected_track.size();

  function automatic logic signed [63:0] fshift(input logic signed [63:0] v, input int s);
    return v >>> s;
  endfunction

  // Rotate the move into the radial frame, add it and vector back to polar form.
  task automatic dead_reckon(input logic [63:0] move_km);
    logic [31:0]        th;
    logic [31:0]        w;
    logic signed [63:0] x, y, a, b, dx, dy;
    logic [63:0]        mag;
    logic [1:0]         quad;
    begin
      th = {16'(heading_q - trk_az), 16'h0};
      quad = th[31:30];
      x = ((move_km << GUARD) * 64'd10187996 + 64'd8388608) >> 24;
      y = 0;
      w = 0;
      if (quad == 2'd1 || quad == 2'd2) begin
        x = -x;
        th = th + 32'h8000_0000;
      end
      for (int i = 0; i < 16; i++) begin
        dx = fshift(y, i);
        dy = fshift(x, i);
        if (!th[31]) begin
          x = x - dx; y = y + dy; th = th - atan_lut(i[4:0]);
        end else begin
          x = x + dx; y = y - dy; th = th + atan_lut(i[4:0]);
        end
      end
      a = $signed(trk_range << GUARD) + x;
      b = y;
      if (a < 0) begin
        a = -a;
        b = -b;
        w = 32'h8000_0000;
      end
      for (int i = 0; i < 16; i++) begin
        dx = fshift(b, i);
        dy = fshift(a, i);
        if (b >= 0) begin
          a = a + dx; b = b - dy; w = w + atan_lut(i[4:0]);
        end else begin
          a = a - dx; b = b + dy; w = w - atan_lut(i[4:0]);
        end
      end
      if (a < 0) a = 0;
      mag = (a * 64'd10187996 + 64'd134217728) >> 28;
      trk_range = (mag > RANGE_CAP) ? RANGE_CAP : mag;
      w = w + 32'h8000;
      trk_az = trk_az + w[31:16];
    end
  endtask

  // Apply one input word to the shadow track and queue the resulting word.
  task automatic predict_track(input op_t op, input logic [15:0] dt);
    logic [63:0] move_km;
    track_word_t t;
    begin
      if (op == OP_TICK && trk_alive) begin
        move_km = (64'(speed_q) * dt * 64'd9050195 + 64'h8000_0000) >> 32;
        if (move_km != 0) dead_reckon(move_km);
        if (trk_range <= 64'(territory_q) && !friendly_q) trk_pen = 1'b1;
        trk_timer = (trk_timer > 32'hFFFF_FFFF - dt) ? 32'hFFFF_FFFF : trk_timer + dt;
      end else if (op == OP_DESTROY) begin
        trk_alive = 1'b0;
      end else if (op == OP_RESTART) begin
        trk_range = 64'(start_rng_q);
        trk_az = start_az_q;
        trk_alive = 1'b1;
        trk_pen = 1'b0;
        trk_timer = 0;
      end
      t.range_now = trk_range[20:0];
      t.azimuth_now = trk_az;
      t.alive_flag = trk_alive;
      t.in_territory = trk_pen;
      t.sweep_age_ms = trk_timer;
      expected_track.push_back(t);
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    begin
      $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    track_word_t e;
    if (!rst_n) begin
      speed_q <= '0; heading_q <= '0; friendly_q <= 1'b0;
      territory_q <= 21'd163840; start_rng_q <= '0; start_az_q <= '0;
      trk_range = 0; trk_az = 0; trk_alive = 1'b1; trk_pen = 1'b0; trk_timer = 0;
      expected_track.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_SPEED:     speed_q <= cfg_data[10:0];
          CFG_HEADING:   heading_q <= cfg_data[15:0];
          CFG_FRIENDLY:  friendly_q <= cfg_data[0];
          CFG_TERRITORY: territory_q <= cfg_data;
          CFG_START_RNG: start_rng_q <= cfg_data;
          CFG_START_AZ:  start_az_q <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) predict_track(op_t'(in_mon.op), in_mon.dt_ms);
      if (out_mon.valid && out_mon.ready) begin
        if (expected_track.size() == 0) begin
          report_mismatch("unexpected word", out_mon.range_now, 0);
        end else begin
          e = expected_track.pop_front();
          if (out_mon.range_now !== e.range_now)
            report_mismatch("range_now", out_mon.range_now, e.range_now);
          if (out_mon.azimuth_now !== e.azimuth_now)
            report_mismatch("azimuth_now", out_mon.azimuth_now, e.azimuth_now);
          if (out_mon.alive_flag !== e.alive_flag)
            report_mismatch("alive_flag", out_mon.alive_flag, e.alive_flag);
          if (out_mon.in_territory !== e.in_territory)
            report_mismatch("in_territory", out_mon.in_territory, e.in_territory);
          if (out_mon.sweep_age_ms !== e.sweep_age_ms)
            report_mismatch("sweep_age_ms", out_mon.sweep_age_ms, e.sweep_age_ms);
        end
      end
    end
  end

  initial fail_count = 0;
endmodule

/* bench/polar_track_position_step_tb.sv */
`timescale 1ns / 1ps

module polar_track_position_step_tb;
  import ptps_pkg::*;

  localparam longint CYCLE_LIMIT = 2_000_000;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [20:0] cfg_data;
  int          fail_count;
  int          pending_words;
  longint      cycle_count;
  int          burst_left;
  int          stall_phase;
  logic        hold_off;

  ptps_in_if  in_ch ();
  ptps_out_if out_ch ();

  polar_track_position_step u_dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  ptps_track_checker u_chk (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_mon(in_ch.source), .out_mon(out_ch.sink),
    .fail_count(fail_count), .pending_words(pending_words)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Watchdog on the cycle count.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // The receiver stalls on a repeating pattern, with a quiet stretch now and then.
  always @(posedge clk) begin
    stall_phase <= (stall_phase + 1) % 97;
    out_ch.ready <= (stall_phase > 60) || (stall_phase % 5 != 0 && stall_phase % 7 != 3);
  end

  // One register write; the write enable is then dropped again before the task returns.
  task automatic write_reg(input cfg_idx_t idx, input logic [20:0] val);
    begin
      cfg_we <= 1'b1;
      cfg_index <= idx;
      cfg_data <= val;
      @(posedge clk);
      cfg_we <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Send one word; the sender idles between bursts of random length.
  task automatic send_word(input op_t op, input logic [15:0] dt);
    begin
      if (burst_left == 0) begin
        repeat ($urandom_range(1, 6)) @(posedge clk);
        burst_left = $urandom_range(1, 8);
      end
      in_ch.valid <= 1'b1;
      in_ch.op <= op;
      in_ch.dt_ms <= dt;
      @(posedge clk);
      while (!in_ch.ready) @(posedge clk);
      burst_left--;
      if (burst_left == 0) in_ch.valid <= 1'b0;
    end
  endtask

  task automatic drain_track;
    begin
      if (burst_left != 0) in_ch.valid <= 1'b0;
      burst_left = 0;
      @(posedge clk);
      while (pending_words != 0) @(posedge clk);
      repeat (150) @(posedge clk);
    end
  endtask

  function automatic logic [15:0] random_dt();
    case ($urandom_range(0, 4))
      0: return 16'($urandom_range(0, 3));
      1: return 16'hFFFF;
      default: return 16'($urandom_range(0, 4000));
    endcase
  endfunction

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.op = OP_TICK;
    in_ch.dt_ms = '0;
    out_ch.ready = 1'b0;
    cycle_count = 0;
    stall_phase = 0;
    burst_left = 0;
    hold_off = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: track at the origin, zero distance, all op codes, extremes.
    send_word(OP_TICK, 16'd0);
    send_word(OP_TICK, 16'hFFFF);
    send_word(OP_NONE, 16'hFFFF);
    drain_track();
    write_reg(CFG_SPEED, 21'd2047);
    write_reg(CFG_HEADING, 21'd16384);
    write_reg(CFG_START_RNG, 21'h1FFFFF);
    write_reg(CFG_START_AZ, 21'hFFFF);
    write_reg(CFG_TERRITORY, 21'h1FFFFF);
    write_reg(cfg_idx_t'(3'd7), 21'h1FFFFF);
    send_word(OP_RESTART, 16'd0);
    send_word(OP_TICK, 16'hFFFF);
    send_word(OP_TICK, 16'd1);
    send_word(OP_DESTROY, 16'd5);
    send_word(OP_TICK, 16'hFFFF);
    send_word(OP_RESTART, 16'hFFFF);
    drain_track();
    // Move straight back through the origin.
    write_reg(CFG_HEADING, 21'd32768);
    write_reg(CFG_START_RNG, 21'd4096);
    write_reg(CFG_START_AZ, 21'd0);
    write_reg(CFG_FRIENDLY, 21'd1);
    write_reg(CFG_TERRITORY, 21'd0);
    write_reg(CFG_SPEED, 21'd100);
    send_word(OP_RESTART, 16'd0);
    for (int k = 0; k < 6; k++) send_word(OP_TICK, 16'd20000);
    drain_track();

    // Random phases, with fresh settings written while the block is idle.
    for (int ph = 0; ph < 15; ph++) begin
      write_reg(CFG_SPEED, ph == 0 ? 21'd0 : 21'($urandom_range(0, 2047)));
      write_reg(CFG_HEADING, 21'($urandom_range(0, 65535)));
      write_reg(CFG_FRIENDLY, 21'($urandom_range(0, 1)));
      write_reg(CFG_TERRITORY, ph == 1 ? 21'h1FFFFF : 21'($urandom_range(0, 400000)));
      write_reg(CFG_START_RNG, ph == 2 ? 21'h1FFFFF : 21'($urandom_range(0, 600000)));
      write_reg(CFG_START_AZ, 21'($urandom_range(0, 65535)));
      for (int k = 0; k < 48; k++) begin
        case ($urandom_range(0, 19))
          0: send_word(OP_DESTROY, 16'($urandom));
          1: send_word(OP_RESTART, 16'($urandom));
          2: send_word(OP_NONE, 16'($urandom));
          default: send_word(OP_TICK, random_dt());
        endcase
        // Once, let every result come back before carrying on.
        if (ph == 7 && k == 20 && !hold_off) begin
          hold_off = 1'b1;
          drain_track();
        end
      end
      drain_track();
    end

    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
